### hw/rtl/srg_pkg.sv
package srg_pkg;

  localparam int TableLen   = 55;
  localparam int ShuffleMul = 21;
  localparam int SecondInit = 32;
  localparam int FillSteps  = 54;
  localparam int WarmPasses = 4;
  localparam int DivSteps   = 3;

  localparam logic [30:0] Modulus   = 31'd1000000000;
  localparam logic [27:0] SeedBase  = 28'd161803398;
  localparam logic [27:0] SeedReset = 28'd14051987;

  // floor(2^61 / 10^9)
  localparam logic [31:0] DivRecip  = 32'd2305843009;

  typedef struct packed {
    logic load_in;
    logic seed_init;
    logic fill_step;
    logic sub_wr;
    logic mul;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } sts_t;

  // a - b modulo 10^9, both operands below 10^9
  function automatic logic [29:0] mod_sub(input logic [29:0] a, input logic [29:0] b);
    logic [30:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[30]) begin
      d = d + Modulus;
    end
    return d[29:0];
  endfunction

  // cursor step over positions 1..55
  function automatic logic [5:0] advance(input logic [5:0] c);
    logic [5:0] n;
    if (c >= 6'(TableLen)) begin
      n = 6'd1;
    end else begin
      n = c + 6'd1;
    end
    return n;
  endfunction

endpackage

### hw/rtl/srg_ctrl.sv
module srg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  srg_pkg::sts_t    sts_i,
  output srg_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSeed = 4'd1;
  localparam logic [3:0] StFill = 4'd2;
  localparam logic [3:0] StWrd  = 4'd3;
  localparam logic [3:0] StWwr  = 4'd4;
  localparam logic [3:0] StDrd  = 4'd5;
  localparam logic [3:0] StDwr  = 4'd6;
  localparam logic [3:0] StMul  = 4'd7;
  localparam logic [3:0] StDiv  = 4'd8;
  localparam logic [3:0] StDone = 4'd9;

  logic [3:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] pass_q, pass_d;
  logic       seeded_q, seeded_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pass_d   = pass_q;
    seeded_d = seeded_q;
    cmd_o    = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = seeded_q ? StDrd : StSeed;
        end
      end
      StSeed: begin
        cmd_o.seed_init = 1'b1;
        cnt_d   = '0;
        state_d = StFill;
      end
      StFill: begin
        cmd_o.fill_step = 1'b1;
        if (cnt_q == 6'(srg_pkg::FillSteps - 1)) begin
          cnt_d   = '0;
          pass_d  = '0;
          state_d = StWrd;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      StWrd: begin
        state_d = StWwr;
      end
      StWwr: begin
        cmd_o.sub_wr = 1'b1;
        state_d = StWrd;
        if (cnt_q == 6'(srg_pkg::TableLen - 1)) begin
          cnt_d = '0;
          if (pass_q == 2'(srg_pkg::WarmPasses - 1)) begin
            seeded_d = 1'b1;
            state_d  = StDrd;
          end else begin
            pass_d = pass_q + 2'd1;
          end
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      StDrd: begin
        state_d = StDwr;
      end
      StDwr: begin
        cmd_o.sub_wr = 1'b1;
        state_d = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        cnt_d   = '0;
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == 6'(srg_pkg::DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = StDone;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      StDone: begin
        if (!sts_i.out_blocked) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      pass_q   <= '0;
      seeded_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pass_q   <= pass_d;
      seeded_q <= seeded_d;
    end
  end

  a_seeded_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seeded_q |=> seeded_q)
    else $error("seeded flag dropped");

  a_no_load_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_blocked)
    else $error("result loaded over a waiting result");

  a_seed_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.seed_init |-> !seeded_q)
    else $error("table seeded twice");

endmodule

### hw/rtl/srg_dpath.sv
module srg_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srg_pkg::cmd_t        cmd_i,
  output srg_pkg::sts_t        sts_o,
  input  logic                 cfg_valid_i,
  input  logic [27:0]          seed_magnitude_i,
  input  logic signed [30:0]   lower_bound_i,
  input  logic signed [30:0]   upper_bound_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [29:0]          raw_value_o,
  output logic signed [30:0]   scaled_value_o,
  output logic                 bad_bounds_o
);

  logic [29:0] lag_mem [srg_pkg::TableLen];
  logic [29:0] rd_a_q, rd_b_q;

  logic [27:0] seed_q;
  logic [5:0]  a_q, b_q, pos_q;
  logic [29:0] cur_q, nxt_q;
  logic [29:0] raw_q;
  logic signed [30:0] lower_q;
  logic [31:0] span_q;
  logic        bad_q;
  logic [60:0] prod_q;
  logic [30:0] est_q;
  logic [31:0] rem_q;
  logic [30:0] quot_q;
  logic        out_valid_q;

  logic        we;
  logic [5:0]  wa;
  logic [29:0] wd;
  logic [27:0] start_w;
  logic [29:0] diff_w;
  logic [6:0]  pos_sum;
  logic [32:0] span_w;
  logic [60:0] prod_w;
  logic [63:0] est_w;
  logic [31:0] back_w;
  logic [1:0]  fix_w;
  logic [31:0] sum_w;

  assign start_w = (seed_q > srg_pkg::SeedBase) ? (seed_q - srg_pkg::SeedBase)
                                                 : (srg_pkg::SeedBase - seed_q);
  assign diff_w  = srg_pkg::mod_sub(rd_a_q, rd_b_q);
  assign pos_sum = {1'b0, pos_q} + 7'(srg_pkg::ShuffleMul);
  assign span_w  = {{2{upper_bound_i[30]}}, upper_bound_i}
                 - {{2{lower_bound_i[30]}}, lower_bound_i} + 33'd1;
  assign prod_w  = {31'd0, raw_q} * {29'd0, span_q};
  // quotient estimate, low by at most two
  assign est_w   = {32'd0, prod_q[60:29]} * {32'd0, srg_pkg::DivRecip};
  assign back_w  = {1'b0, est_q} * {1'b0, srg_pkg::Modulus};
  assign fix_w   = (rem_q >= {srg_pkg::Modulus, 1'b0}) ? 2'd2 :
                   (rem_q >= {1'b0, srg_pkg::Modulus}) ? 2'd1 : 2'd0;
  assign sum_w   = {lower_q[30], lower_q} + {1'b0, quot_q};

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = diff_w;
    if (cmd_i.seed_init) begin
      we = 1'b1;
      wa = 6'(srg_pkg::TableLen - 1);
      wd = {2'b00, start_w};
    end else if (cmd_i.fill_step) begin
      we = 1'b1;
      wa = pos_q - 6'd1;
      wd = nxt_q;
    end else if (cmd_i.sub_wr) begin
      we = 1'b1;
      wa = a_q - 6'd1;
      wd = diff_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      lag_mem[wa] <= wd;
    end
    rd_a_q <= lag_mem[a_q - 6'd1];
    rd_b_q <= lag_mem[b_q - 6'd1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= srg_pkg::SeedReset;
      a_q         <= 6'd1;
      b_q         <= 6'(srg_pkg::SecondInit);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        seed_q <= seed_magnitude_i;
      end
      if (cmd_i.sub_wr) begin
        a_q <= srg_pkg::advance(a_q);
        b_q <= srg_pkg::advance(b_q);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      lower_q <= lower_bound_i;
      span_q  <= span_w[31:0];
      bad_q   <= (upper_bound_i < lower_bound_i);
    end
    if (cmd_i.seed_init) begin
      cur_q <= {2'b00, start_w};
      nxt_q <= 30'd1;
      pos_q <= 6'(srg_pkg::ShuffleMul);
    end else if (cmd_i.fill_step) begin
      cur_q <= nxt_q;
      nxt_q <= srg_pkg::mod_sub(cur_q, nxt_q);
      pos_q <= (pos_sum >= 7'(srg_pkg::TableLen)) ? 6'(pos_sum - 7'(srg_pkg::TableLen))
                                                   : pos_sum[5:0];
    end
    if (cmd_i.sub_wr) begin
      raw_q <= diff_w;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_w;
    end
    if (cmd_i.div_step) begin
      est_q  <= est_w[62:32];
      rem_q  <= prod_q[31:0] - back_w;
      quot_q <= est_q + {29'd0, fix_w};
    end
    if (cmd_i.out_load) begin
      raw_value_o    <= raw_q;
      scaled_value_o <= bad_q ? lower_q : sum_w[30:0];
      bad_bounds_o   <= bad_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sts_o.out_blocked = out_valid_q & out_stall_i;

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_q >= 6'd1) && (a_q <= 6'(srg_pkg::TableLen)))
    else $error("first cursor out of range");

  a_cursor_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_q == a_q + 6'd31) || (b_q == a_q - 6'd24))
    else $error("cursors lost their lag");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_o)
    else $error("loaded result not presented");

endmodule

### hw/rtl/subtractive_random_generator_top.sv
// Subtractive lagged random generator, 55-word table modulo 10^9.
// Input channel: in_valid_i / in_stall_o with lower_bound_i, upper_bound_i.
//   A request is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with raw_value_o,
//   scaled_value_o and bad_bounds_o; one result per request.
// Config channel: cfg_valid_i / cfg_ready_o with seed_magnitude_i; ready is
//   always high. The seed is used only by the seeding pass.
// For a seeded table, an accepted request goes through the table read and
//   write-back, the multiply, the reciprocal divide by 10^9 and the result
//   load before out_valid_o rises.
// The first request after reset also seeds the table: a seeding write, the
//   fill steps and 4 x 55 warm-up steps, each a table read and write-back.
// No new request is taken until the previous one has loaded its result;
//   the next request is taken while a result still waits on the output.
// Reset clears the cursors, the seeded flag and the output valid, and
//   restores the seed register to its default.
// While the receiver stalls, the result holds; a finished request waits
//   in the controller until the output register is free.
module subtractive_random_generator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [27:0]        seed_magnitude_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [30:0] lower_bound_i,
  input  logic signed [30:0] upper_bound_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [29:0]        raw_value_o,
  output logic signed [30:0] scaled_value_o,
  output logic               bad_bounds_o
);

  srg_pkg::cmd_t cmd;
  srg_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  srg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srg_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .seed_magnitude_i (seed_magnitude_i),
    .lower_bound_i    (lower_bound_i),
    .upper_bound_i    (upper_bound_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .raw_value_o      (raw_value_o),
    .scaled_value_o   (scaled_value_o),
    .bad_bounds_o     (bad_bounds_o)
  );

endmodule
